[rtl/core/cbm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [15:0] ADDR_CHR_FIRST = 16'hB000;
	localparam logic [15:0] ADDR_CHR_LAST  = 16'hE00C;
	localparam logic [15:0] ADDR_PRG0      = 16'h8010;
	localparam logic [15:0] ADDR_PRG1      = 16'hA010;
	localparam logic [15:0] ADDR_MIRROR    = 16'h9400;
	localparam logic [15:0] ADDR_IRQ_LO    = 16'hF000;
	localparam logic [15:0] ADDR_IRQ_HI    = 16'hF004;
	localparam logic [15:0] ADDR_IRQ_CTL   = 16'hF008;

	localparam logic [7:0] CHR_LOCK_CLR = 8'hC8;
	localparam logic [7:0] CHR_LOCK_SET = 8'h88;
	localparam logic [7:0] CHR_RAM_PG0  = 8'h04;
	localparam logic [7:0] CHR_RAM_PG1  = 8'h05;

	localparam logic [10:0] DOTS_PER_LINE = 11'd341;
	localparam int          IRQ_FIRE_BIT  = 8;

	typedef enum logic [1:0] {
		IRQ_OP_TICK,
		IRQ_OP_LATCH_LO,
		IRQ_OP_LATCH_HI,
		IRQ_OP_CTRL
	} irq_op_t;

	typedef struct packed {
		logic    start;
		irq_op_t op;
		logic [7:0] arg;
	} irq_req_t;

	typedef struct packed {
		logic done;
		logic pending;
	} irq_stat_t;

endpackage

`default_nettype wire

[rtl/core/cbm_irq.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbm_irq
	import cbm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire irq_req_t  req,
	output irq_stat_t      stat
);

	typedef enum logic [0:0] {
		S_IDLE,
		S_SUB
	} state_t;

	state_t      state_q;
	logic [10:0] acc_q;
	logic [8:0]  dot_q;
	logic [12:0] cnt_q;
	logic [11:0] latch_q;
	logic        en_q;
	logic        pend_q;
	logic        done_q;

	logic [12:0] cnt_inc;
	logic [10:0] acc_add;

	assign cnt_inc = cnt_q + 13'd1;
	// dots = accumulator + 3 * cycles
	assign acc_add = {2'b00, dot_q} + {2'b00, req.arg, 1'b0} + {3'b000, req.arg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			acc_q   <= '0;
			dot_q   <= '0;
			cnt_q   <= '0;
			latch_q <= '0;
			en_q    <= 1'b0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						unique case (req.op)
							IRQ_OP_TICK: begin
								if (en_q) begin
									acc_q   <= acc_add;
									state_q <= S_SUB;
								end else begin
									done_q <= 1'b1;
								end
							end
							IRQ_OP_LATCH_LO: begin
								pend_q  <= 1'b0;
								latch_q <= {4'h0, latch_q[7:4], req.arg[3:0]};
								done_q  <= 1'b1;
							end
							IRQ_OP_LATCH_HI: begin
								pend_q  <= 1'b0;
								latch_q <= {req.arg, latch_q[3:0]};
								done_q  <= 1'b1;
							end
							IRQ_OP_CTRL: begin
								pend_q <= 1'b0;
								dot_q  <= '0;
								cnt_q  <= {1'b0, latch_q};
								en_q   <= req.arg[1];
								done_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_SUB: begin
					// one scanline per cycle
					if (acc_q >= DOTS_PER_LINE) begin
						acc_q <= acc_q - DOTS_PER_LINE;
						if (cnt_inc[IRQ_FIRE_BIT]) begin
							pend_q <= 1'b1;
							cnt_q  <= {1'b0, latch_q};
						end else begin
							cnt_q <= cnt_inc;
						end
					end else begin
						dot_q   <= acc_q[8:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign stat.done    = done_q;
	assign stat.pending = pend_q;

endmodule

`default_nettype wire

[rtl/core/cbm_remap.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbm_remap
	import cbm_pkg::*;
#(
	parameter int CHR_SLOTS = 8,
	parameter int SLOT_W    = $clog2(CHR_SLOTS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic [SLOT_W-1:0]      idx,
	input  wire logic [7:0]        chr_lo,
	input  wire logic [3:0]        chr_hi,
	output logic                   done,
	input  wire logic [SLOT_W-1:0] rd_slot,
	output logic [11:0]            rd_page,
	output logic                   rd_ram
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHR_SLOTS - 1);

	logic [SLOT_W-1:0] idx_q;
	logic              busy_q;
	logic              done_q;
	logic              lock_q;
	logic [11:0]       page_q [CHR_SLOTS];
	logic              ram_q  [CHR_SLOTS];

	logic              to_ram;

	assign to_ram = ((chr_lo == CHR_RAM_PG0) || (chr_lo == CHR_RAM_PG1)) && !lock_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			lock_q <= 1'b0;
			for (int i = 0; i < CHR_SLOTS; i++) begin
				page_q[i] <= '0;
				ram_q[i]  <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				priority if (chr_lo == CHR_LOCK_CLR) begin
					lock_q <= 1'b0;
				end else if (chr_lo == CHR_LOCK_SET) begin
					lock_q <= 1'b1;
				end else if (to_ram) begin
					page_q[idx_q] <= {11'd0, chr_lo[0]};
					ram_q[idx_q]  <= 1'b1;
				end else begin
					page_q[idx_q] <= {chr_hi, chr_lo};
					ram_q[idx_q]  <= 1'b0;
				end
				if (idx_q == LAST_SLOT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					idx_q  <= '0;
				end else begin
					idx_q <= idx_q + SLOT_W'(1);
				end
			end else if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end
		end
	end

	assign idx     = idx_q;
	assign done    = done_q;
	assign rd_page = page_q[rd_slot];
	assign rd_ram  = ram_q[rd_slot];

endmodule

`default_nettype wire

[rtl/core/cartridge_bank_mapper_irq.sv]
`timescale 1ns / 1ps
`default_nettype none

// Cartridge bank mapper with scanline IRQ counter. Each input beat is either a
// CPU write (s_tuser = 0) or a tick of elapsed CPU time (s_tuser = 1), and
// produces exactly one result beat with the IRQ line, both PRG banks, the
// mirroring mode and the CHR mapping of the queried slot after the beat took
// effect. One beat is in flight at a time. A CHR, PRG or mirroring write
// starts a remap that walks the CHR slots one per cycle. A tick subtracts one
// scanline of 341 dots per cycle while the IRQ counter is enabled; IRQ
// register writes also go through the IRQ block, writes to unmapped addresses
// straight to the result. The next beat is taken while a result still waits
// on the master side. No clearing pass after reset.
module cartridge_bank_mapper_irq
	import cbm_pkg::*;
#(
	parameter int CHR_SLOTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // address[15:0], data[23:16], cpu_cycles[31:24], chr_slot[34:32], zero
	input  wire logic        s_tuser,  // command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // irq_line[0], prg_bank_first[8:1], prg_bank_second[16:9],
	                                   // mirroring[18:17], chr_page[30:19], chr_from_ram[31]
);

	localparam int SLOT_W = $clog2(CHR_SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT_REMAP,
		ST_WAIT_IRQ,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [SLOT_W-1:0] slot_q;
	logic              m_tvalid_q;
	logic [31:0]       m_tdata_q;
	logic [7:0]        chr_lo_q [CHR_SLOTS];
	logic [3:0]        chr_hi_q [CHR_SLOTS];
	logic [7:0]        prg0_q;
	logic [7:0]        prg1_q;
	logic [1:0]        mirror_q;

	logic [15:0]       in_addr;
	logic [7:0]        in_data;
	logic [7:0]        in_cyc;
	logic [2:0]        in_slot;
	logic              accept;
	logic              is_wr;
	logic              hit_chr;
	logic              hit_prg0;
	logic              hit_prg1;
	logic              hit_mir;
	logic              hit_lo;
	logic              hit_hi;
	logic              hit_ctl;
	logic [15:0]       chr_sel;
	logic [SLOT_W-1:0] chr_idx;
	logic              remap_start;
	irq_req_t          irq_req;
	irq_stat_t         irq_stat;
	logic [SLOT_W-1:0] rm_idx;
	logic              rm_done;
	logic [11:0]       rd_page;
	logic              rd_ram;

	assign in_addr = s_tdata[15:0];
	assign in_data = s_tdata[23:16];
	assign in_cyc  = s_tdata[31:24];
	assign in_slot = s_tdata[34:32];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_wr    = (s_tuser == CMD_WRITE);

	assign hit_chr  = (in_addr >= ADDR_CHR_FIRST) && (in_addr <= ADDR_CHR_LAST);
	assign hit_prg0 = (in_addr == ADDR_PRG0);
	assign hit_prg1 = (in_addr == ADDR_PRG1);
	assign hit_mir  = (in_addr == ADDR_MIRROR);
	assign hit_lo   = (in_addr == ADDR_IRQ_LO);
	assign hit_hi   = (in_addr == ADDR_IRQ_HI);
	assign hit_ctl  = (in_addr == ADDR_IRQ_CTL);

	// CHR slot from address bits 3, 11, 12, 13, offset by two
	assign chr_sel = (((in_addr & 16'h0008) | (in_addr >> 8)) >> 3) + 16'd2;
	assign chr_idx = chr_sel[SLOT_W-1:0];

	assign remap_start = accept && is_wr && (hit_chr || hit_prg0 || hit_prg1 || hit_mir);

	always_comb begin
		irq_req.start = accept && (!is_wr || hit_lo || hit_hi || hit_ctl);
		irq_req.arg   = is_wr ? in_data : in_cyc;
		priority if (!is_wr) begin
			irq_req.op = IRQ_OP_TICK;
		end else if (hit_lo) begin
			irq_req.op = IRQ_OP_LATCH_LO;
		end else if (hit_hi) begin
			irq_req.op = IRQ_OP_LATCH_HI;
		end else begin
			irq_req.op = IRQ_OP_CTRL;
		end
	end

	cbm_irq u_irq (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (irq_req),
		.stat   (irq_stat)
	);

	cbm_remap #(
		.CHR_SLOTS (CHR_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_remap (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (remap_start),
		.idx     (rm_idx),
		.chr_lo  (chr_lo_q[rm_idx]),
		.chr_hi  (chr_hi_q[rm_idx]),
		.done    (rm_done),
		.rd_slot (slot_q),
		.rd_page (rd_page),
		.rd_ram  (rd_ram)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			slot_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			prg0_q     <= '0;
			prg1_q     <= '0;
			mirror_q   <= '0;
			for (int i = 0; i < CHR_SLOTS; i++) begin
				chr_lo_q[i] <= '0;
				chr_hi_q[i] <= '0;
			end
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						slot_q <= in_slot[SLOT_W-1:0];
						if (irq_req.start) begin
							state_q <= ST_WAIT_IRQ;
						end else if (remap_start) begin
							state_q <= ST_WAIT_REMAP;
						end else begin
							state_q <= ST_DONE;
						end
						if (is_wr) begin
							priority if (hit_chr) begin
								if (!in_addr[2]) begin
									chr_lo_q[chr_idx][3:0] <= in_data[3:0];
								end else begin
									chr_lo_q[chr_idx][7:4] <= in_data[3:0];
									chr_hi_q[chr_idx]      <= in_data[7:4];
								end
							end else if (hit_prg0) begin
								prg0_q <= in_data;
							end else if (hit_prg1) begin
								prg1_q <= in_data;
							end else if (hit_mir) begin
								mirror_q <= in_data[1:0];
							end else begin
							end
						end
					end
				end
				ST_WAIT_REMAP: begin
					if (rm_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_WAIT_IRQ: begin
					if (irq_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {rd_ram, rd_page, mirror_q, prg1_q, prg0_q,
						               irq_stat.pending};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire
